// ===== design/rasa_pkg.sv =====
// ----------------------------------------------------------------------------
// rasa_pkg: shared types and constants for the rotation source address core
// Word layouts, configuration register indexes and the quarter-wave sine
// table built at elaboration.
// ----------------------------------------------------------------------------
package rasa_pkg;

    localparam int MAX_DIM        = 1024;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int ANGLE_STEPS    = 360;
    localparam int QUARTER        = ANGLE_STEPS / 4;

    localparam int ANGLE_W = 9;
    localparam int COORD_W = 10;
    localparam int DIM_W   = 11;
    localparam int QIDX_W  = $clog2(QUARTER + 1);

    // unsigned table entry (sin 90 deg is exactly 2^TRIG_FRAC_BITS)
    localparam int TRIG_W  = TRIG_FRAC_BITS + 1;
    // signed sine / cosine
    localparam int STRIG_W = TRIG_W + 1;
    // signed offset from the center
    localparam int DELTA_W = DIM_W;
    localparam int PROD_W  = STRIG_W + DELTA_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int QUOT_W  = SUM_W - TRIG_FRAC_BITS;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Q64 reciprocals for the table build: floor(n / d) = (n * ceil(2^64 / d)) >> 64,
    // exact for every numerator the series produces (none of the divisors is a
    // power of two, so the ceiling is the floor plus one)
    localparam logic [127:0] ONE_Q64     = 128'd1 << 64;
    localparam logic [127:0] RECIP_ANGLE = ONE_Q64 / 128'(ANGLE_STEPS) + 128'd1;
    // divisor (2n)(2n+1) of Taylor term n sits at index n-1
    localparam logic [9:0][127:0] RECIP_TAYLOR =
    {
        ONE_Q64 / 128'd420 + 128'd1,
        ONE_Q64 / 128'd342 + 128'd1,
        ONE_Q64 / 128'd272 + 128'd1,
        ONE_Q64 / 128'd210 + 128'd1,
        ONE_Q64 / 128'd156 + 128'd1,
        ONE_Q64 / 128'd110 + 128'd1,
        ONE_Q64 / 128'd72  + 128'd1,
        ONE_Q64 / 128'd42  + 128'd1,
        ONE_Q64 / 128'd20  + 128'd1,
        ONE_Q64 / 128'd6   + 128'd1
    };

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_deg;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
    } in_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic               inside_res;
    } out_word_t;

    typedef struct packed {
        logic signed [STRIG_W-1:0] sin_val;
        logic signed [STRIG_W-1:0] cos_val;
    } trig_t;

    typedef logic [QUARTER:0][TRIG_W-1:0] sin_table_t;

    // numerator times Q64 reciprocal, integer part
    function automatic logic [63:0] mul_recip(input logic [63:0] num,
                                              input logic [127:0] recip);
        logic [127:0] prod;
        prod = {64'd0, num} * recip;
        return prod[127:64];
    endfunction

    // round(sin(k deg) * 2^TRIG_FRAC_BITS) from a Q30 Taylor series
    function automatic logic [TRIG_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        x    = mul_recip(64'(k) * PI_Q30 * 64'd2, RECIP_ANGLE);
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 10; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = mul_recip(term, RECIP_TAYLOR[n-1]);
            if ((n % 2) == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        rnd = ($unsigned(sum) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
        return rnd[TRIG_W-1:0];
    endfunction

    function automatic sin_table_t build_sin_table();
        sin_table_t t;
        for (int k = 0; k <= QUARTER; k++)
            t[k] = quarter_sine(k);
        return t;
    endfunction

    localparam sin_table_t SIN_TABLE = build_sin_table();

endpackage

// ===== design/rasa_in_if.sv =====
// ----------------------------------------------------------------------------
// rasa_in_if: destination pixel word channel
// Valid/ready handshake carrying angle and destination coordinate.
// ----------------------------------------------------------------------------
interface rasa_in_if;
    logic               valid;
    logic               ready;
    rasa_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rasa_out_if.sv =====
// ----------------------------------------------------------------------------
// rasa_out_if: source address word channel
// Valid/ready handshake carrying source coordinate and inside flag.
// ----------------------------------------------------------------------------
interface rasa_out_if;
    logic                valid;
    logic                ready;
    rasa_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rasa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rasa_cfg_if: configuration write channel
// Valid/ready handshake carrying register index and write data.
// ----------------------------------------------------------------------------
interface rasa_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rasa_pkg::CFG_IDX_W-1:0]     index;
    logic [rasa_pkg::DIM_W-1:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/rasa_trig_lookup.sv =====
// ----------------------------------------------------------------------------
// rasa_trig_lookup: angle to signed sine and cosine
// Wraps the angle into 0..359, folds it onto the quarter-wave table and
// applies the quadrant signs.
// ----------------------------------------------------------------------------
module rasa_trig_lookup
(
    input  logic [rasa_pkg::ANGLE_W-1:0] angle_deg,
    output rasa_pkg::trig_t              trig
);

    localparam int Q1 = rasa_pkg::QUARTER;
    localparam int Q2 = 2 * rasa_pkg::QUARTER;
    localparam int Q3 = 3 * rasa_pkg::QUARTER;
    localparam int Q4 = 4 * rasa_pkg::QUARTER;
    localparam int AW = rasa_pkg::ANGLE_W;
    localparam int IW = rasa_pkg::QIDX_W;
    localparam int SW = rasa_pkg::STRIG_W;

    logic [AW-1:0]         a_wrap;
    logic [AW-1:0]         sin_full;
    logic [AW-1:0]         cos_full;
    logic                  sin_neg;
    logic                  cos_neg;
    logic signed [SW-1:0]  sin_mag;
    logic signed [SW-1:0]  cos_mag;

    // one subtraction covers the whole 9-bit input range
    assign a_wrap = (angle_deg >= AW'(Q4)) ? angle_deg - AW'(Q4) : angle_deg;

    always_comb
    begin
        if (a_wrap <= AW'(Q1))
        begin
            sin_full = a_wrap;
            cos_full = AW'(Q1) - a_wrap;
            sin_neg  = 1'b0;
            cos_neg  = 1'b0;
        end
        else if (a_wrap <= AW'(Q2))
        begin
            sin_full = AW'(Q2) - a_wrap;
            cos_full = a_wrap - AW'(Q1);
            sin_neg  = 1'b0;
            cos_neg  = 1'b1;
        end
        else if (a_wrap <= AW'(Q3))
        begin
            sin_full = a_wrap - AW'(Q2);
            cos_full = AW'(Q3) - a_wrap;
            sin_neg  = 1'b1;
            cos_neg  = 1'b1;
        end
        else
        begin
            sin_full = AW'(Q4) - a_wrap;
            cos_full = a_wrap - AW'(Q3);
            sin_neg  = 1'b1;
            cos_neg  = 1'b0;
        end
    end

    assign sin_mag = $signed({1'b0, rasa_pkg::SIN_TABLE[sin_full[IW-1:0]]});
    assign cos_mag = $signed({1'b0, rasa_pkg::SIN_TABLE[cos_full[IW-1:0]]});

    assign trig.sin_val = sin_neg ? -sin_mag : sin_mag;
    assign trig.cos_val = cos_neg ? -cos_mag : cos_mag;

endmodule

// ===== design/image_rotation_source_address_core.sv =====
// ----------------------------------------------------------------------------
// image_rotation_source_address_core: nearest-neighbor rotation source address
// Inverse maps an output pixel through a rotation about the image center and
// reports the source pixel plus whether it falls inside the image.
// ----------------------------------------------------------------------------
// Each stage holds one word; an accepted word passes them in order to pix_out.
// Throughput: one word per cycle while pix_out is ready; the three pipeline
//   stages (trig lookup, products, sum/truncate/bounds) advance on demand.
// Reset (rst_n low, asynchronous): pipeline empties, image size returns to
//   640 x 480. Configuration writes are accepted in every cycle.
module image_rotation_source_address_core
(
    input  logic              clk,
    input  logic              rst_n,
    rasa_cfg_if.sink          cfg,
    rasa_in_if.sink           pix_in,
    rasa_out_if.source        pix_out
);

    localparam int FB = rasa_pkg::TRIG_FRAC_BITS;
    localparam int DW = rasa_pkg::DIM_W;
    localparam int CW = rasa_pkg::COORD_W;
    localparam int SW = rasa_pkg::STRIG_W;
    localparam int XW = rasa_pkg::DELTA_W;
    localparam int PW = rasa_pkg::PROD_W;
    localparam int UW = rasa_pkg::SUM_W;
    localparam int QW = rasa_pkg::QUOT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rasa_pkg::WIDTH_RESET;
            height_reg <= rasa_pkg::HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rasa_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                rasa_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // sizes above MAX_DIM act as MAX_DIM; center is the integer half
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;

    assign w_eff = (width_reg  > DW'(rasa_pkg::MAX_DIM)) ? DW'(rasa_pkg::MAX_DIM) : width_reg;
    assign h_eff = (height_reg > DW'(rasa_pkg::MAX_DIM)) ? DW'(rasa_pkg::MAX_DIM) : height_reg;
    assign cx    = w_eff[DW-1:1];
    assign cy    = h_eff[DW-1:1];

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or drains forward
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    assign adv3         = !v3_reg || pix_out.ready;
    assign adv2         = !v2_reg || adv3;
    assign adv1         = !v1_reg || adv2;
    assign pix_in.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= pix_in.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: angle -> sin/cos, destination -> offset from center
    // ------------------------------------------------------------------
    rasa_pkg::trig_t       trig;
    logic signed [SW-1:0]  sin1_reg, cos1_reg;
    logic signed [XW-1:0]  dx1_reg, dy1_reg;
    logic signed [XW-1:0]  dx1_next, dy1_next;

    rasa_trig_lookup u_trig
    (
        .angle_deg (pix_in.data.angle_deg),
        .trig      (trig)
    );

    assign dx1_next = $signed({1'b0, pix_in.data.dest_x}) - $signed({1'b0, cx});
    assign dy1_next = $signed({1'b0, pix_in.data.dest_y}) - $signed({1'b0, cy});

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            sin1_reg <= trig.sin_val;
            cos1_reg <= trig.cos_val;
            dx1_reg  <= dx1_next;
            dy1_reg  <= dy1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the four rotation products, exact
    // ------------------------------------------------------------------
    logic signed [PW-1:0] cdx2_reg, sdy2_reg, sdx2_reg, cdy2_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            cdx2_reg <= PW'(cos1_reg) * PW'(dx1_reg);
            sdy2_reg <= PW'(sin1_reg) * PW'(dy1_reg);
            sdx2_reg <= PW'(sin1_reg) * PW'(dx1_reg);
            cdy2_reg <= PW'(cos1_reg) * PW'(dy1_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add center, truncate toward zero, bounds check
    // ------------------------------------------------------------------
    logic signed [UW-1:0] sum_x, sum_y;
    logic signed [UW-1:0] cx_fix, cy_fix;
    logic [UW-1:0]        mag_x, mag_y;
    logic [QW-1:0]        q_x, q_y;
    logic                 neg_x, neg_y;
    logic                 src_in_img;
    rasa_pkg::out_word_t  out_next;
    rasa_pkg::out_word_t  out_reg;

    assign cx_fix = $signed(UW'({cx, {FB{1'b0}}}));
    assign cy_fix = $signed(UW'({cy, {FB{1'b0}}}));

    assign sum_x = UW'(cdx2_reg) + UW'(sdy2_reg) + cx_fix;
    assign sum_y = UW'(cdy2_reg) - UW'(sdx2_reg) + cy_fix;

    assign neg_x = sum_x[UW-1];
    assign neg_y = sum_y[UW-1];
    assign mag_x = neg_x ? $unsigned(-sum_x) : $unsigned(sum_x);
    assign mag_y = neg_y ? $unsigned(-sum_y) : $unsigned(sum_y);
    assign q_x   = mag_x[UW-1:FB];
    assign q_y   = mag_y[UW-1:FB];

    // a negative sum only survives truncation as zero when it is above -1
    assign src_in_img = (!neg_x || (q_x == '0)) && (q_x < QW'(w_eff)) &&
                        (!neg_y || (q_y == '0)) && (q_y < QW'(h_eff));

    always_comb
    begin
        out_next.inside_res = src_in_img;
        out_next.src_x      = src_in_img ? q_x[CW-1:0] : '0;
        out_next.src_y      = src_in_img ? q_y[CW-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
            out_reg <= out_next;
    end

    assign pix_out.valid = v3_reg;
    assign pix_out.data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !v3_reg |-> pix_in.ready)
        else $error("input stalled with an empty output stage");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v3_reg) |-> $past(v2_reg))
        else $error("result word appeared without a word in the product stage");

    a_inside_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && pix_out.data.inside_res) |->
        ((DW'(pix_out.data.src_x) < w_eff) && (DW'(pix_out.data.src_y) < h_eff)))
        else $error("inside result lies outside the image");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && !pix_out.data.inside_res) |->
        ((pix_out.data.src_x == '0) && (pix_out.data.src_y == '0)))
        else $error("outside result carries a nonzero address");

endmodule
